/* src/lsa_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the logic and shift unit.
package lsa_pkg;

    // Operation codes carried in the command field
    typedef enum logic [2:0] {
        CMD_AND = 3'd0,
        CMD_OR  = 3'd1,
        CMD_XOR = 3'd2,
        CMD_NOT = 3'd3,
        CMD_SHL = 3'd4,
        CMD_SHR = 3'd5
    } cmd_t;

    localparam int unsigned DATA_W  = 16;
    localparam int unsigned COUNT_W = 5;

    localparam logic [DATA_W-1:0] MASK_BYTE = 16'h00FF;
    localparam logic [DATA_W-1:0] MASK_WORD = 16'hFFFF;

    // One operation with its operands and the current flags
    typedef struct packed {
        cmd_t              command;
        logic              word_size;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic              carry_in;
        logic              parity_in;
        logic              zero_in;
        logic              sign_in;
        logic              overflow_in;
    } op_item_t;

    // One result with the new flags
    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              carry_out;
        logic              parity_out;
        logic              zero_out;
        logic              sign_out;
        logic              overflow_out;
    } res_item_t;

endpackage

/* src/lsa_exec.sv */
`timescale 1ns / 1ps
// Combinational logic, shift and flag computation for one item.
module lsa_exec
    import lsa_pkg::*;
(
    input  op_item_t  op,
    output res_item_t res
);

    logic                   wide;
    logic [DATA_W-1:0]      mask;
    logic [DATA_W-1:0]      a;
    logic [DATA_W-1:0]      b;
    logic [COUNT_W-1:0]     count;
    logic [COUNT_W-1:0]     count_m1;
    logic [2*DATA_W-1:0]    shl_pre;
    logic [DATA_W-1:0]      shl_res;
    logic                   shl_cf;
    logic [DATA_W-1:0]      shr_pre;
    logic [DATA_W-1:0]      shr_res;
    logic                   shr_cf;
    logic [DATA_W-1:0]      value;
    logic                   cf;
    logic                   of;
    logic                   set_szp;
    logic                   res_msb;

    // Trim operands to the selected width
    assign wide     = op.word_size;
    assign mask     = wide ? MASK_WORD : MASK_BYTE;
    assign a        = op.operand_a & mask;
    assign b        = op.operand_b & mask;
    assign count    = op.operand_b[COUNT_W-1:0];
    assign count_m1 = count - COUNT_W'(1);

    // Shift by count minus one so the last bit out is at a fixed place
    assign shl_pre = {{DATA_W{1'b0}}, a} << count_m1;
    assign shl_cf  = wide ? shl_pre[15] : shl_pre[7];
    assign shl_res = (shl_pre[DATA_W-1:0] << 1) & mask;

    assign shr_pre = a >> count_m1;
    assign shr_cf  = shr_pre[0];
    assign shr_res = shr_pre >> 1;

    // Select the result and the carry and overflow flags
    always_comb
    begin
        value   = a;
        cf      = op.carry_in;
        of      = op.overflow_in;
        set_szp = 1'b0;
        case (op.command)
            CMD_AND:
            begin
                value   = a & b;
                cf      = 1'b0;
                of      = 1'b0;
                set_szp = 1'b1;
            end
            CMD_OR:
            begin
                value   = a | b;
                cf      = 1'b0;
                of      = 1'b0;
                set_szp = 1'b1;
            end
            CMD_XOR:
            begin
                value   = a ^ b;
                cf      = 1'b0;
                of      = 1'b0;
                set_szp = 1'b1;
            end
            CMD_NOT:
            begin
                value = ~a & mask;
            end
            CMD_SHL:
            begin
                if (count != '0)
                begin
                    value   = shl_res;
                    cf      = shl_cf;
                    set_szp = 1'b1;
                    if (count == COUNT_W'(1))
                    begin
                        of = (wide ? shl_res[15] : shl_res[7]) ^ shl_cf;
                    end
                end
            end
            CMD_SHR:
            begin
                if (count != '0)
                begin
                    value   = shr_res;
                    cf      = shr_cf;
                    set_szp = 1'b1;
                    if (count == COUNT_W'(1))
                    begin
                        of = wide ? a[15] : a[7];
                    end
                end
            end
            default:
            begin
                value = a;
            end
        endcase
    end

    // Update sign, zero and parity from the result, or hold the incoming flags
    assign res_msb          = wide ? value[15] : value[7];
    assign res.result       = value;
    assign res.carry_out    = cf;
    assign res.overflow_out = of;
    assign res.zero_out     = set_szp ? (value == '0) : op.zero_in;
    assign res.sign_out     = set_szp ? res_msb : op.sign_in;
    assign res.parity_out   = set_szp ? ~^value[7:0] : op.parity_in;

endmodule

/* src/logic_shift_alu_8_16.sv */
`timescale 1ns / 1ps
// Top level of the 8/16-bit logic and shift unit with its item registers.
//
// Operation channel: op carries the command, operand width, two operands
// and the current CF, PF, ZF, SF and OF flags; it is taken at a rising edge
// where op_valid is high and op_stall is low.
// Result channel: res carries the result and the new flags; it is taken at
// a rising edge where res_valid is high and res_stall is low.
//
// An accepted item is held in the input register, evaluated by the logic,
// shift and flag path, and lands in the result register, which raises
// res_valid when it takes the item; the result is then taken at an edge
// where res_stall is low. One item is accepted every cycle while the result
// side takes one every cycle; the registered result behind the combinational
// evaluation path sets that rate.
//
// When res_stall is high the result register holds its item; the input
// register still fills, and op_stall rises only when both registers are
// full. Reset empties both registers and drops res_valid; the item
// registers themselves are not reset.
module logic_shift_alu_8_16
    import lsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      op_valid,
    output logic      op_stall,
    input  op_item_t  op,
    output logic      res_valid,
    input  logic      res_stall,
    output res_item_t res
);

    logic      in_valid_reg;
    logic      in_valid_next;
    op_item_t  in_item_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    res_item_t out_item_reg;
    res_item_t exec_res;
    logic      adv_out;
    logic      adv_in;

    // Advance each register when it is empty or its item moves on
    assign adv_out  = !out_valid_reg || !res_stall;
    assign adv_in   = !in_valid_reg || adv_out;
    assign op_stall = !adv_in;

    assign in_valid_next  = adv_in ? op_valid : in_valid_reg;
    assign out_valid_next = adv_out ? in_valid_reg : out_valid_reg;

    // Clear valid flags under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming item
    always_ff @(posedge clk)
    begin
        if (adv_in)
        begin
            in_item_reg <= op;
        end
    end

    lsa_exec u_exec (
        .op  (in_item_reg),
        .res (exec_res)
    );

    // Capture the evaluated result
    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            out_item_reg <= exec_res;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_item_reg;

    // Stall upstream only with both registers holding items
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        op_stall |-> (in_valid_reg && out_valid_reg))
        else $error("op_stall raised with a free register");

    // An item in the input register moves to the result register when it frees
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && adv_out) |=> out_valid_reg)
        else $error("item lost between input and result registers");

    // A taken result with nothing behind it leaves the output empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_stall && !in_valid_reg) |=> !out_valid_reg)
        else $error("result repeated after it was taken");

    // A stalled result register keeps its item
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_stall) |=> (out_valid_reg && $stable(out_item_reg)))
        else $error("stalled result changed");

endmodule
